>>> hw/rtl/ftm_pkg.sv
// Shared constants, codes and controller/datapath interface types of the flow threshold monitor.
package ftm_pkg;

	localparam int COUNT_WIDTH_DEFAULT  = 16;
	localparam int SAMPLE_WIDTH_DEFAULT = 32;

	localparam int REG_WIDTH    = 32;
	localparam int PERIOD_WIDTH = 16;
	localparam int VALUE_WIDTH  = 32;
	localparam int SEQ_WIDTH    = 32;
	localparam int STATUS_WIDTH = 2;
	localparam int CFG_INDEX_W  = 3;

	localparam int OUT_FIELDS_W = STATUS_WIDTH + VALUE_WIDTH + SEQ_WIDTH;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [PERIOD_WIDTH-1:0] READ_PERIOD_RESET    = PERIOD_WIDTH'(1);
	localparam logic [PERIOD_WIDTH-1:0] PUBLISH_PERIOD_RESET = PERIOD_WIDTH'(300);

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD_LOW  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD_HIGH = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_READ_PERIOD    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_PUBLISH_PERIOD = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_RUN_ENABLE     = 3'd4;

	// Status codes.
	localparam logic [STATUS_WIDTH-1:0] STATUS_GOOD = 2'd0;
	localparam logic [STATUS_WIDTH-1:0] STATUS_LOW  = 2'd1;
	localparam logic [STATUS_WIDTH-1:0] STATUS_HIGH = 2'd2;
	localparam logic [STATUS_WIDTH-1:0] STATUS_NONE = 2'd3;

	// Report kinds.
	localparam logic KIND_ALERT    = 1'b0;
	localparam logic KIND_PERIODIC = 1'b1;

	typedef struct packed {
		logic start;
		logic eval;
		logic load_alert;
		logic div_start;
		logic load_pub;
	} ftm_cmd_t;

	typedef struct packed {
		logic run_en;
		logic alert_hit;
		logic pub_hit;
		logic div_done;
		logic out_free;
	} ftm_sts_t;

endpackage

>>> hw/rtl/ftm_div.sv
// Bit-serial signed divider for the window mean: one quotient bit per cycle.
module ftm_div #(
	parameter int COUNT_WIDTH  = ftm_pkg::COUNT_WIDTH_DEFAULT,
	parameter int SAMPLE_WIDTH = ftm_pkg::SAMPLE_WIDTH_DEFAULT
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	input  logic signed [SAMPLE_WIDTH+COUNT_WIDTH-1:0] dividend,
	input  logic [COUNT_WIDTH-1:0]                    divisor,
	output logic                                      done,
	output logic signed [SAMPLE_WIDTH-1:0]            quotient
);

	localparam int SUM_W = SAMPLE_WIDTH + COUNT_WIDTH;
	localparam int CNT_W = $clog2(SUM_W + 1);

	logic                   busy_q;
	logic                   done_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [COUNT_WIDTH-1:0] rem_q;
	logic [SUM_W-1:0]       quo_q;
	logic [COUNT_WIDTH-1:0] div_q;
	logic                   neg_q;

	logic [COUNT_WIDTH:0]   rem_shift;
	logic                   fits;
	logic [COUNT_WIDTH:0]   rem_diff;
	logic [SUM_W-1:0]       quo_signed;

	assign rem_shift  = {rem_q, quo_q[SUM_W-1]};
	assign fits       = rem_shift >= {1'b0, div_q};
	assign rem_diff   = rem_shift - {1'b0, div_q};
	assign quo_signed = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;
	assign quotient   = quo_signed[SAMPLE_WIDTH-1:0];
	assign done       = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			// An empty window divides to zero without iterating.
			busy_q <= (divisor != '0);
			done_q <= (divisor == '0);
			cnt_q  <= CNT_W'(SUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			if (divisor == '0) begin
				quo_q <= '0;
				neg_q <= 1'b0;
			end else begin
				quo_q <= dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
				neg_q <= dividend[SUM_W-1];
			end
		end else if (busy_q) begin
			rem_q <= fits ? rem_diff[COUNT_WIDTH-1:0] : rem_shift[COUNT_WIDTH-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

`ifndef SYNTHESIS
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && divisor != '0) |=> (busy_q && !done_q))
		else $error("divider not busy after a start with a nonzero divisor");
	a_busy_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && done_q))
		else $error("divider busy and done at once");
`endif

endmodule

>>> hw/rtl/ftm_ctrl.sv
// Controller state machine of the flow threshold monitor: sequences one tick through its steps.
module ftm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  ftm_pkg::ftm_sts_t sts,
	output ftm_pkg::ftm_cmd_t cmd
);

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_EVAL      = 3'd1;
	localparam logic [2:0] S_ALERT     = 3'd2;
	localparam logic [2:0] S_DIV_START = 3'd3;
	localparam logic [2:0] S_DIV_WAIT  = 3'd4;
	localparam logic [2:0] S_PUB       = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				// A tick taken while disabled is dropped without effect.
				if (s_tvalid && sts.run_en) begin
					cmd.start = 1'b1;
					state_d   = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (sts.alert_hit) begin
					state_d = S_ALERT;
				end else if (sts.pub_hit) begin
					state_d = S_DIV_START;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_ALERT: begin
				if (sts.out_free) begin
					cmd.load_alert = 1'b1;
					state_d        = sts.pub_hit ? S_DIV_START : S_IDLE;
				end
			end
			S_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (sts.div_done) begin
					state_d = S_PUB;
				end
			end
			S_PUB: begin
				if (sts.out_free) begin
					cmd.load_pub = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_alert || cmd.load_pub) |-> sts.out_free)
		else $error("report loaded into an occupied output register");
	a_pub_has_mean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUB) |-> sts.div_done)
		else $error("periodic report step without a finished mean");
	a_div_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !sts.div_done || (state_q == S_DIV_WAIT))
		else $error("divider start did not lead to the wait step");
`endif

endmodule

>>> hw/rtl/ftm_dpath.sv
// Datapath of the flow threshold monitor: registers, counters, window, classifier and output register.
module ftm_dpath #(
	parameter int COUNT_WIDTH  = ftm_pkg::COUNT_WIDTH_DEFAULT,
	parameter int SAMPLE_WIDTH = ftm_pkg::SAMPLE_WIDTH_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wen,
	input  logic [ftm_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [ftm_pkg::REG_WIDTH-1:0]         cfg_data,
	input  logic signed [SAMPLE_WIDTH-1:0]        flow_sample,
	input  ftm_pkg::ftm_cmd_t                     cmd,
	output ftm_pkg::ftm_sts_t                     sts,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic                                  report_kind,
	output logic [ftm_pkg::STATUS_WIDTH-1:0]      report_status,
	output logic signed [ftm_pkg::VALUE_WIDTH-1:0] report_value,
	output logic [ftm_pkg::SEQ_WIDTH-1:0]         sequence_number,
	output logic                                  last_report
);

	localparam int SUM_W   = SAMPLE_WIDTH + COUNT_WIDTH;
	localparam int CMP_W   = (SAMPLE_WIDTH > ftm_pkg::REG_WIDTH) ? SAMPLE_WIDTH
		: ftm_pkg::REG_WIDTH;
	localparam int CNT_CMP_W = (COUNT_WIDTH > ftm_pkg::PERIOD_WIDTH) ? COUNT_WIDTH
		: ftm_pkg::PERIOD_WIDTH;

	logic signed [ftm_pkg::REG_WIDTH-1:0]  thr_low_q;
	logic signed [ftm_pkg::REG_WIDTH-1:0]  thr_high_q;
	logic [ftm_pkg::PERIOD_WIDTH-1:0]      read_period_q;
	logic [ftm_pkg::PERIOD_WIDTH-1:0]      publish_period_q;
	logic                                  run_en_q;

	logic [COUNT_WIDTH-1:0]                tick_q;
	logic [COUNT_WIDTH-1:0]                read_q;
	logic signed [SUM_W-1:0]               sum_q;
	logic [COUNT_WIDTH-1:0]                samples_q;
	logic [ftm_pkg::STATUS_WIDTH-1:0]      last_status_q;
	logic [ftm_pkg::SEQ_WIDTH-1:0]         report_cnt_q;
	logic signed [SAMPLE_WIDTH-1:0]        sample_q;

	logic                                  out_valid_q;
	logic                                  out_kind_q;
	logic [ftm_pkg::STATUS_WIDTH-1:0]      out_status_q;
	logic signed [ftm_pkg::VALUE_WIDTH-1:0] out_value_q;
	logic [ftm_pkg::SEQ_WIDTH-1:0]         out_seq_q;
	logic                                  out_last_q;

	logic signed [CMP_W-1:0]               thr_low_x;
	logic signed [CMP_W-1:0]               thr_high_x;
	logic signed [CMP_W-1:0]               sample_x;
	logic signed [CMP_W-1:0]               mean_x;
	logic signed [SAMPLE_WIDTH-1:0]        mean;
	logic [ftm_pkg::STATUS_WIDTH-1:0]      sample_status;
	logic [ftm_pkg::STATUS_WIDTH-1:0]      mean_status;
	logic                                  read_hit;
	logic                                  div_done;
	logic                                  out_free;

	// Below the low limit wins over above the high limit, also when the limits cross.
	function automatic logic [ftm_pkg::STATUS_WIDTH-1:0] classify(
		input logic signed [CMP_W-1:0] v,
		input logic signed [CMP_W-1:0] lo,
		input logic signed [CMP_W-1:0] hi
	);
		logic [ftm_pkg::STATUS_WIDTH-1:0] st;
		if (v < lo) begin
			st = ftm_pkg::STATUS_LOW;
		end else if (v > hi) begin
			st = ftm_pkg::STATUS_HIGH;
		end else begin
			st = ftm_pkg::STATUS_GOOD;
		end
		return st;
	endfunction

	assign thr_low_x     = CMP_W'(thr_low_q);
	assign thr_high_x    = CMP_W'(thr_high_q);
	assign sample_x      = CMP_W'(sample_q);
	assign mean_x        = CMP_W'(mean);
	assign sample_status = classify(sample_x, thr_low_x, thr_high_x);
	assign mean_status   = classify(mean_x, thr_low_x, thr_high_x);
	assign read_hit      = CNT_CMP_W'(read_q) >= CNT_CMP_W'(read_period_q);
	assign out_free      = !out_valid_q || out_ready;

	assign sts.run_en    = run_en_q;
	assign sts.alert_hit = read_hit && (sample_status != last_status_q);
	assign sts.pub_hit   = CNT_CMP_W'(tick_q) == CNT_CMP_W'(publish_period_q);
	assign sts.div_done  = div_done;
	assign sts.out_free  = out_free;

	ftm_div #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(sum_q),
		.divisor (samples_q),
		.done    (div_done),
		.quotient(mean)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_low_q        <= '0;
			thr_high_q       <= '0;
			read_period_q    <= ftm_pkg::READ_PERIOD_RESET;
			publish_period_q <= ftm_pkg::PUBLISH_PERIOD_RESET;
			run_en_q         <= 1'b0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				ftm_pkg::CFG_THRESHOLD_LOW:  thr_low_q  <= cfg_data;
				ftm_pkg::CFG_THRESHOLD_HIGH: thr_high_q <= cfg_data;
				ftm_pkg::CFG_READ_PERIOD:
					read_period_q <= cfg_data[ftm_pkg::PERIOD_WIDTH-1:0];
				ftm_pkg::CFG_PUBLISH_PERIOD:
					publish_period_q <= cfg_data[ftm_pkg::PERIOD_WIDTH-1:0];
				ftm_pkg::CFG_RUN_ENABLE:     run_en_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q        <= '0;
			read_q        <= '0;
			sum_q         <= '0;
			samples_q     <= '0;
			last_status_q <= ftm_pkg::STATUS_NONE;
			report_cnt_q  <= '0;
		end else begin
			if (cmd.start) begin
				tick_q <= tick_q + COUNT_WIDTH'(1);
				read_q <= read_q + COUNT_WIDTH'(1);
			end
			if (cmd.eval && read_hit) begin
				read_q        <= '0;
				last_status_q <= sample_status;
				// A full window keeps classifying but stops accumulating.
				if (samples_q != '1) begin
					sum_q     <= sum_q + SUM_W'(sample_q);
					samples_q <= samples_q + COUNT_WIDTH'(1);
				end
			end
			if (cmd.load_alert || cmd.load_pub) begin
				report_cnt_q <= report_cnt_q + ftm_pkg::SEQ_WIDTH'(1);
			end
			if (cmd.load_pub) begin
				tick_q    <= '0;
				read_q    <= '0;
				sum_q     <= '0;
				samples_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sample_q <= flow_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_alert || cmd.load_pub) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_alert) begin
			out_kind_q   <= ftm_pkg::KIND_ALERT;
			out_status_q <= last_status_q;
			out_value_q  <= sample_x[ftm_pkg::VALUE_WIDTH-1:0];
			out_seq_q    <= report_cnt_q + ftm_pkg::SEQ_WIDTH'(1);
			out_last_q   <= !sts.pub_hit;
		end else if (cmd.load_pub) begin
			out_kind_q   <= ftm_pkg::KIND_PERIODIC;
			out_status_q <= mean_status;
			out_value_q  <= mean_x[ftm_pkg::VALUE_WIDTH-1:0];
			out_seq_q    <= report_cnt_q + ftm_pkg::SEQ_WIDTH'(1);
			out_last_q   <= 1'b1;
		end
	end

	assign out_valid       = out_valid_q;
	assign report_kind     = out_kind_q;
	assign report_status   = out_status_q;
	assign report_value    = out_value_q;
	assign sequence_number = out_seq_q;
	assign last_report     = out_last_q;

`ifndef SYNTHESIS
	a_no_alert_without_read: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.eval && !read_hit) |=> (last_status_q == $past(last_status_q)))
		else $error("status changed on a tick that did not read");
`endif

endmodule

>>> hw/rtl/flow_threshold_monitor.sv
// Top level of the flow threshold monitor: tick stream in, alert and periodic report stream out.
//
// Each accepted tick carries one flow sample. A tick that gives no report passes the evaluate
// step only; an alert report adds the alert step, and a periodic report adds the window mean
// division, done by a bit-serial divider at one quotient bit per cycle (no iterations for an
// empty window), then the publish step. A report step waits while the output register is full
// and the report stream holds tready low. Reports leave through an output register, so the next tick
// is taken while the last report still waits for its transfer. Ticks taken while run_enable
// is 0 are dropped. There is no clearing pass after reset. Configuration is to be written only
// while the block is idle; the block itself does not enforce it.
module flow_threshold_monitor #(
	parameter int COUNT_WIDTH  = ftm_pkg::COUNT_WIDTH_DEFAULT,
	parameter int SAMPLE_WIDTH = ftm_pkg::SAMPLE_WIDTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [ftm_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ftm_pkg::REG_WIDTH-1:0]       cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// flow_sample, then zero fill
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// report_status, report_value, sequence_number, then zero fill
	output logic [ftm_pkg::OUT_DATA_W-1:0]      m_tdata,
	// report_kind
	output logic                                m_tuser,
	output logic                                m_tlast
);

	ftm_pkg::ftm_cmd_t                      cmd;
	ftm_pkg::ftm_sts_t                      sts;
	logic [ftm_pkg::STATUS_WIDTH-1:0]       report_status;
	logic signed [ftm_pkg::VALUE_WIDTH-1:0] report_value;
	logic [ftm_pkg::SEQ_WIDTH-1:0]          sequence_number;

	ftm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	ftm_dpath #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.flow_sample    (s_tdata[SAMPLE_WIDTH-1:0]),
		.cmd            (cmd),
		.sts            (sts),
		.out_ready      (m_tready),
		.out_valid      (m_tvalid),
		.report_kind    (m_tuser),
		.report_status  (report_status),
		.report_value   (report_value),
		.sequence_number(sequence_number),
		.last_report    (m_tlast)
	);

	assign m_tdata = ftm_pkg::OUT_DATA_W'({sequence_number, report_value, report_status});

endmodule

>>> sim/tb.sv
// Testbench for the flow threshold monitor: directed and random ticks checked against a predictor.
module tb;

	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 100;

	typedef struct packed {
		logic                             kind;
		logic [ftm_pkg::STATUS_WIDTH-1:0] status;
		logic [ftm_pkg::VALUE_WIDTH-1:0]  value;
		logic [ftm_pkg::SEQ_WIDTH-1:0]    seq;
		logic                             last;
	} report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [ftm_pkg::CFG_INDEX_W-1:0] cfg_index = ftm_pkg::CFG_THRESHOLD_LOW;
	logic [ftm_pkg::REG_WIDTH-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [ftm_pkg::OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	// Predictor copy of the registers.
	logic [31:0] lim_low = '0;
	logic [31:0] lim_high = '0;
	logic [15:0] read_every = ftm_pkg::READ_PERIOD_RESET;
	logic [15:0] publish_every = ftm_pkg::PUBLISH_PERIOD_RESET;
	logic enabled = 1'b0;

	// Predictor copy of the monitor state.
	logic [15:0] ticks_since_pub = '0;
	logic [15:0] ticks_since_read = '0;
	logic [47:0] win_total = '0;
	logic [15:0] win_count = '0;
	logic [ftm_pkg::STATUS_WIDTH-1:0] prev_status = ftm_pkg::STATUS_NONE;
	logic [ftm_pkg::SEQ_WIDTH-1:0] seq_count = '0;

	logic [31:0] tick_samples[$];
	report_t pending_reports[$];
	int mismatches = 0;
	int quiet_cycles = 0;
	int tick_gap_pct = 0;
	int ready_stall_pct = 0;

	flow_threshold_monitor u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	function automatic logic [ftm_pkg::STATUS_WIDTH-1:0] grade_flow(longint v);
		if (v < longint'($signed(lim_low)))
			return ftm_pkg::STATUS_LOW;
		if (v > longint'($signed(lim_high)))
			return ftm_pkg::STATUS_HIGH;
		return ftm_pkg::STATUS_GOOD;
	endfunction

	function automatic report_t make_report(logic kind, logic [ftm_pkg::STATUS_WIDTH-1:0] st,
			logic [31:0] val);
		report_t r;
		seq_count = seq_count + 1'b1;
		r.kind = kind;
		r.status = st;
		r.value = val;
		r.seq = seq_count;
		r.last = 1'b0;
		return r;
	endfunction

	// Works out the reports that one accepted tick causes.
	function automatic void advance_monitor(logic [31:0] raw);
		longint sample;
		longint mean;
		logic [ftm_pkg::STATUS_WIDTH-1:0] st;
		report_t alert_r;
		report_t pub_r;
		logic has_alert;
		logic has_pub;
		has_alert = 1'b0;
		has_pub = 1'b0;
		if (!enabled)
			return;
		ticks_since_pub = ticks_since_pub + 1'b1;
		ticks_since_read = ticks_since_read + 1'b1;
		if (ticks_since_read >= read_every) begin
			sample = longint'($signed(raw));
			st = grade_flow(sample);
			ticks_since_read = '0;
			// A full window still classifies reads but stops summing them.
			if (win_count != 16'hFFFF) begin
				win_total = win_total + 48'(sample);
				win_count = win_count + 1'b1;
			end
			if (st != prev_status) begin
				prev_status = st;
				alert_r = make_report(ftm_pkg::KIND_ALERT, st, raw);
				has_alert = 1'b1;
			end
		end
		if (ticks_since_pub == publish_every) begin
			mean = 0;
			if (win_count != 0)
				mean = longint'($signed(win_total)) / longint'(win_count);
			pub_r = make_report(ftm_pkg::KIND_PERIODIC, grade_flow(mean), mean[31:0]);
			has_pub = 1'b1;
			ticks_since_pub = '0;
			ticks_since_read = '0;
			win_total = '0;
			win_count = '0;
		end
		if (has_pub) begin
			pub_r.last = 1'b1;
		end else if (has_alert) begin
			alert_r.last = 1'b1;
		end
		if (has_alert)
			pending_reports.insert(pending_reports.size(), alert_r);
		if (has_pub)
			pending_reports.insert(pending_reports.size(), pub_r);
	endfunction

	function automatic void check_report();
		report_t got;
		report_t want;
		got.kind = m_tuser;
		got.status = m_tdata[1:0];
		got.value = m_tdata[33:2];
		got.seq = m_tdata[65:34];
		got.last = m_tlast;
		if (pending_reports.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("report with none predicted: kind %0d status %0d value %h seq %0d last %0d",
					got.kind, got.status, got.value, got.seq, got.last);
			return;
		end
		want = pending_reports.pop_front();
		if (got.kind != want.kind || got.status != want.status || got.value != want.value ||
				got.seq != want.seq || got.last != want.last) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("report mismatch: expected kind %0d status %0d value %h seq %0d last %0d",
					want.kind, want.status, want.value, want.seq, want.last);
				$display("                 got      kind %0d status %0d value %h seq %0d last %0d",
					got.kind, got.status, got.value, got.seq, got.last);
			end
		end
	endfunction

	// Tick source: pops pending samples and predicts each one as its transfer completes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				advance_monitor(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (tick_samples.size() != 0 && $urandom_range(99) >= tick_gap_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= tick_samples.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Report sink with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_report();
			m_tready <= ($urandom_range(99) >= ready_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic void queue_tick(logic [31:0] sample);
		tick_samples.insert(tick_samples.size(), sample);
	endfunction

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(5))
			0, 1: return $urandom();
			2: return lim_low + 32'($urandom_range(4)) - 32'd2;
			3: return lim_high + 32'($urandom_range(4)) - 32'd2;
			4: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $urandom_range(1) ? lim_low : lim_high;
		endcase
	endfunction

	task automatic write_cfg(logic [ftm_pkg::CFG_INDEX_W-1:0] idx,
			logic [ftm_pkg::REG_WIDTH-1:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			ftm_pkg::CFG_THRESHOLD_LOW: lim_low = val;
			ftm_pkg::CFG_THRESHOLD_HIGH: lim_high = val;
			ftm_pkg::CFG_READ_PERIOD: read_every = val[15:0];
			ftm_pkg::CFG_PUBLISH_PERIOD: publish_every = val[15:0];
			ftm_pkg::CFG_RUN_ENABLE: enabled = val[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic apply_setting(logic [31:0] lo, logic [31:0] hi, logic [15:0] rd,
			logic [15:0] pb);
		write_cfg(ftm_pkg::CFG_THRESHOLD_LOW, lo);
		write_cfg(ftm_pkg::CFG_THRESHOLD_HIGH, hi);
		write_cfg(ftm_pkg::CFG_READ_PERIOD, {16'b0, rd});
		write_cfg(ftm_pkg::CFG_PUBLISH_PERIOD, {16'b0, pb});
		write_cfg(ftm_pkg::CFG_RUN_ENABLE, 32'd1);
	endtask

	// Waits until every tick is taken and every report is in, then lets the block go idle.
	task automatic settle();
		@(negedge clk);
		while (tick_samples.size() != 0 || s_tvalid || pending_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [31:0] lo;
		logic [31:0] hi;
		logic [15:0] rd;
		logic [15:0] pb;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Ticks before run_enable is set are dropped.
		queue_tick(32'h1234_5678);
		queue_tick(32'hFFFF_FFFF);
		settle();

		// Threshold boundaries and field extremes.
		apply_setting(32'h0000_0000, 32'h0001_0000, 16'd1, 16'd6);
		queue_tick(32'h0000_0000);
		queue_tick(32'hFFFF_FFFF);
		queue_tick(32'hFFFF_FFFF);
		queue_tick(32'h7FFF_FFFF);
		queue_tick(32'h8000_0000);
		queue_tick(32'h0001_0000);
		queue_tick(32'h0001_0001);
		queue_tick(32'hFFFF_FFFF);
		queue_tick(32'hFFFF_FFFF);
		queue_tick(32'h0000_0000);
		queue_tick(32'h0000_0000);
		queue_tick(32'h0000_0000);
		settle();

		// Crossed limits: the low test wins. Read period zero reads every tick.
		apply_setting(32'h0001_0000, 32'hFFFF_0000, 16'd0, 16'd4);
		queue_tick(32'h0000_8000);
		queue_tick(32'h7FFF_FFFF);
		queue_tick(32'h8000_0000);
		queue_tick(32'h0001_0000);
		settle();

		// Read period longer than publish period leaves the window empty.
		apply_setting(32'h0000_0000, 32'h0001_0000, 16'hFFFF, 16'd3);
		repeat (3) queue_tick(32'h0002_0000);
		settle();

		// Lowering the read period below the read count reads on the next tick.
		apply_setting(32'hFFFF_0000, 32'h0000_0000, 16'd5, 16'd20);
		repeat (3) queue_tick(32'h0000_4000);
		settle();
		write_cfg(ftm_pkg::CFG_READ_PERIOD, 32'd2);
		queue_tick(32'hFFF0_0000);
		queue_tick(32'h0000_4000);
		settle();

		write_cfg(ftm_pkg::CFG_RUN_ENABLE, 32'd0);
		queue_tick(32'h8000_0000);
		queue_tick(32'h7FFF_FFFF);
		settle();

		for (int mode = 0; mode < 4; mode++) begin
			case (mode)
				0: begin tick_gap_pct = 0; ready_stall_pct = 0; end
				1: begin tick_gap_pct = 88; ready_stall_pct = 0; end
				2: begin tick_gap_pct = 0; ready_stall_pct = 88; end
				default: begin tick_gap_pct = 7; ready_stall_pct = 7; end
			endcase
			for (int setting = 0; setting < 4; setting++) begin
				case ($urandom_range(4))
					0: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
					1: begin lo = $urandom(); hi = $urandom(); end
					default: begin
						lo = $urandom();
						hi = lo + $urandom_range(20, 32'h0004_0000);
					end
				endcase
				case ($urandom_range(7))
					0: rd = 16'd0;
					1: rd = 16'hFFFF;
					default: rd = 16'($urandom_range(1, 4));
				endcase
				// Keep the publish point ahead of the tick count so reports keep coming.
				pb = ticks_since_pub + 16'($urandom_range(1, 16));
				apply_setting(lo, hi, rd, pb);
				repeat (36) queue_tick(pick_sample());
				settle();
			end
		end

		// Publish period zero: the tick count stays far from wrapping, so no periodic report.
		tick_gap_pct = 0;
		ready_stall_pct = 0;
		apply_setting(32'h8000_0000, 32'h7FFF_FFFF, 16'd1, 16'd1);
		queue_tick($urandom());
		settle();
		write_cfg(ftm_pkg::CFG_PUBLISH_PERIOD, 32'd0);
		repeat (40) queue_tick($urandom());
		settle();

		if (mismatches == 0 && pending_reports.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

>>> files.f
hw/rtl/ftm_pkg.sv
hw/rtl/ftm_div.sv
hw/rtl/ftm_ctrl.sv
hw/rtl/ftm_dpath.sv
hw/rtl/flow_threshold_monitor.sv
sim/tb.sv
